[design/pnfc_pkg.sv]
// Shared types and constants for the parallel NOR flash command model.
package pnfc_pkg;

   localparam int BUSY_W = 20;
   localparam int CMD_W  = 15;

   localparam logic [CMD_W-1:0] UNLOCK_A = 15'h5555;
   localparam logic [CMD_W-1:0] UNLOCK_B = 15'h2AAA;

   localparam logic [7:0] DAT_AA     = 8'hAA;
   localparam logic [7:0] DAT_55     = 8'h55;
   localparam logic [7:0] CMD_PROG   = 8'hA0;
   localparam logic [7:0] CMD_ERASE  = 8'h80;
   localparam logic [7:0] CMD_SECTOR = 8'h30;
   localparam logic [7:0] CMD_CHIP   = 8'h10;
   localparam logic [7:0] CMD_ID     = 8'h90;
   localparam logic [7:0] CMD_RESET  = 8'hF0;
   localparam logic [7:0] ERASED     = 8'hFF;

   localparam logic [7:0]        VENDOR_RST = 8'hBF;
   localparam logic [7:0]        DEVICE_RST = 8'hB5;
   localparam logic [9:0]        PROG_RST   = 10'd20;
   localparam logic [BUSY_W-1:0] ERASE_RST  = 20'd25000;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_TICK  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CSR_VENDOR = 2'd0,
      CSR_DEVICE = 2'd1,
      CSR_PROG   = 2'd2,
      CSR_ERASE  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      STG_IDLE    = 3'd0,
      STG_AA      = 3'd1,
      STG_CMD     = 3'd2,
      STG_PROG    = 3'd3,
      STG_ERS     = 3'd4,
      STG_ERS_AA  = 3'd5,
      STG_ERS_CMD = 3'd6
   } stage_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      stage_type stage_next;
      logic      id_set;
      logic      id_clr;
      logic      prog;
      logic      erase_sect;
      logic      erase_chip;
   } seq_ctl_type;

endpackage

[design/parallel_nor_flash_command_model_unit.sv]
// Top level of the parallel NOR flash command model.
// A beat is accepted when start is high and busy is low. The accept edge
// launches the array read, the execute state decodes the command and writes
// back, and the result shows on the rsp_ ports for one cycle right after.
// No new beat is accepted while one is in the execute state. The array
// has a single write port: a sector erase holds busy for the sweep of its
// sector, a chip erase for a sweep of the whole array, and after reset a
// clearing pass over the whole array runs before the first beat.
// SECTOR_BYTES must be a power of two. CSR writes are taken in any cycle.
module parallel_nor_flash_command_model_unit #(
   parameter int ADDR_BITS    = 17,
   parameter int SECTOR_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [16:0] req_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_busy_res,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata
);

   localparam int SECT_LOG  = $clog2(SECTOR_BYTES);
   localparam int SECT_BITS = (SECT_LOG < ADDR_BITS) ? SECT_LOG : ADDR_BITS;
   localparam logic [ADDR_BITS-1:0] SECT_MASK  = {ADDR_BITS{1'b1}} >> (ADDR_BITS - SECT_BITS);
   localparam logic [ADDR_BITS-1:0] ADDR_ONES  = {ADDR_BITS{1'b1}};

   pnfc_pkg::state_type state_ff, state_in;
   pnfc_pkg::stage_type stage_ff, stage_in;
   logic [ADDR_BITS-1:0] sweep_ptr_ff, sweep_ptr_in;
   logic [ADDR_BITS-1:0] sweep_last_ff, sweep_last_in;
   logic                 id_ff, id_in;
   logic [pnfc_pkg::BUSY_W-1:0] busy_left_ff, busy_left_in;
   logic                 toggle_ff, toggle_in;
   logic                 poll_ff, poll_in;

   logic [7:0]                  vendor_ff;
   logic [7:0]                  device_ff;
   logic [9:0]                  prog_ticks_ff;
   logic [pnfc_pkg::BUSY_W-1:0] erase_ticks_ff;

   logic [1:0]           act_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [7:0]           data_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_busy_ff, rsp_busy_in;

   logic [ADDR_BITS+16:0] req_addr_wide;
   logic [ADDR_BITS-1:0]  req_addr;
   logic                  accept;
   logic                  busy_now;
   logic                  is_write;
   logic                  do_erase;

   logic                 mem_wr_en;
   logic [ADDR_BITS-1:0] mem_wr_addr;
   logic [7:0]           mem_wr_data;
   logic [7:0]           mem_rd_data;

   pnfc_pkg::seq_ctl_type ctl;

   assign req_addr_wide = {{ADDR_BITS{1'b0}}, req_address};
   assign req_addr      = req_addr_wide[ADDR_BITS-1:0];
   assign busy          = (state_ff != pnfc_pkg::ST_IDLE);
   assign accept        = start && !busy;
   assign busy_now      = (busy_left_ff != '0);
   assign is_write      = (state_ff == pnfc_pkg::ST_EXEC) && (act_ff == pnfc_pkg::ACT_WRITE);
   assign do_erase      = is_write && (ctl.erase_sect || ctl.erase_chip);

   pnfc_seq u_seq (
      .stage    (stage_ff),
      .busy_now (busy_now),
      .wr_en    (is_write),
      .ca       (addr_ff[pnfc_pkg::CMD_W-1:0]),
      .data     (data_ff),
      .ctl      (ctl)
   );

   pnfc_mem #(
      .ADDR_BITS (ADDR_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (mem_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pnfc_pkg::ST_IDLE: begin
            if (start) begin
               state_in = pnfc_pkg::ST_EXEC;
            end
         end
         pnfc_pkg::ST_EXEC: begin
            state_in = do_erase ? pnfc_pkg::ST_SWEEP : pnfc_pkg::ST_IDLE;
         end
         pnfc_pkg::ST_CLEAR, pnfc_pkg::ST_SWEEP: begin
            if (sweep_ptr_ff == sweep_last_ff) begin
               state_in = pnfc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pnfc_pkg::ST_IDLE;
         end
      endcase
   end

   // array write port
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_data = mem_rd_data & data_ff;
      unique case (state_ff)
         pnfc_pkg::ST_CLEAR, pnfc_pkg::ST_SWEEP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_ptr_ff;
            mem_wr_data = pnfc_pkg::ERASED;
         end
         pnfc_pkg::ST_EXEC: begin
            mem_wr_en = is_write && ctl.prog;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      stage_in      = stage_ff;
      id_in         = id_ff;
      busy_left_in  = busy_left_ff;
      toggle_in     = toggle_ff;
      poll_in       = poll_ff;
      sweep_ptr_in  = sweep_ptr_ff + 1'b1;
      sweep_last_in = sweep_last_ff;
      rsp_data_in   = '0;
      if (state_ff == pnfc_pkg::ST_EXEC) begin
         case (act_ff)
            pnfc_pkg::ACT_READ: begin
               if (busy_now) begin
                  rsp_data_in = {poll_ff, toggle_ff, 6'b0};
                  toggle_in   = !toggle_ff;
               end else if (id_ff) begin
                  rsp_data_in = addr_ff[0] ? device_ff : vendor_ff;
               end else begin
                  rsp_data_in = mem_rd_data;
               end
            end
            pnfc_pkg::ACT_WRITE: begin
               stage_in = ctl.stage_next;
               if (ctl.id_set) begin
                  id_in = 1'b1;
               end else if (ctl.id_clr) begin
                  id_in = 1'b0;
               end
               if (ctl.prog) begin
                  poll_in      = !data_ff[7];
                  busy_left_in = (prog_ticks_ff == '0) ? pnfc_pkg::BUSY_W'(1)
                                 : {{(pnfc_pkg::BUSY_W-10){1'b0}}, prog_ticks_ff};
               end
               if (do_erase) begin
                  poll_in      = 1'b0;
                  busy_left_in = (erase_ticks_ff == '0) ? pnfc_pkg::BUSY_W'(1)
                                 : erase_ticks_ff;
                  if (ctl.erase_sect) begin
                     sweep_ptr_in  = addr_ff & ~SECT_MASK;
                     sweep_last_in = addr_ff | SECT_MASK;
                  end else begin
                     sweep_ptr_in  = '0;
                     sweep_last_in = ADDR_ONES;
                  end
               end
            end
            pnfc_pkg::ACT_TICK: begin
               if (busy_now) begin
                  busy_left_in = busy_left_ff - 1'b1;
               end
            end
            default: begin
               rsp_data_in = '0;
            end
         endcase
      end
      rsp_valid_in = (state_ff == pnfc_pkg::ST_EXEC);
      rsp_busy_in  = (busy_left_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pnfc_pkg::ST_CLEAR;
         stage_ff      <= pnfc_pkg::STG_IDLE;
         sweep_ptr_ff  <= '0;
         sweep_last_ff <= ADDR_ONES;
         id_ff         <= 1'b0;
         busy_left_ff  <= '0;
         toggle_ff     <= 1'b0;
         poll_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         stage_ff      <= stage_in;
         sweep_ptr_ff  <= sweep_ptr_in;
         sweep_last_ff <= sweep_last_in;
         id_ff         <= id_in;
         busy_left_ff  <= busy_left_in;
         toggle_ff     <= toggle_in;
         poll_ff       <= poll_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= req_action;
         addr_ff <= req_addr;
         data_ff <= req_write_data;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_busy_ff <= rsp_busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vendor_ff      <= pnfc_pkg::VENDOR_RST;
         device_ff      <= pnfc_pkg::DEVICE_RST;
         prog_ticks_ff  <= pnfc_pkg::PROG_RST;
         erase_ticks_ff <= pnfc_pkg::ERASE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            pnfc_pkg::CSR_VENDOR: vendor_ff      <= csr_wdata[7:0];
            pnfc_pkg::CSR_DEVICE: device_ff      <= csr_wdata[7:0];
            pnfc_pkg::CSR_PROG:   prog_ticks_ff  <= csr_wdata[9:0];
            pnfc_pkg::CSR_ERASE:  erase_ticks_ff <= csr_wdata;
            default:              vendor_ff      <= vendor_ff;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_busy_res  = rsp_busy_ff;

endmodule

[design/pnfc_mem.sv]
// Flash array storage: one write port, one registered read port.
module pnfc_mem #(
   parameter int ADDR_BITS = 17
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [7:0]           wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [7:0]           rd_data
);

   logic [7:0] mem_ff [2**ADDR_BITS];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/pnfc_seq.sv]
// Unlock and command sequencer: decodes one bus write against the current stage.
module pnfc_seq (
   input  pnfc_pkg::stage_type              stage,
   input  logic                             busy_now,
   input  logic                             wr_en,
   input  logic [pnfc_pkg::CMD_W-1:0]       ca,
   input  logic [7:0]                       data,
   output pnfc_pkg::seq_ctl_type            ctl
);

   pnfc_pkg::stage_type restart;
   logic                at_a;
   logic                at_b;

   assign at_a    = (ca == pnfc_pkg::UNLOCK_A);
   assign at_b    = (ca == pnfc_pkg::UNLOCK_B);
   assign restart = (at_a && data == pnfc_pkg::DAT_AA) ? pnfc_pkg::STG_AA
                                                       : pnfc_pkg::STG_IDLE;

   always_comb begin
      ctl            = '0;
      ctl.stage_next = stage;
      if (wr_en && !busy_now) begin
         unique case (stage)
            pnfc_pkg::STG_IDLE: begin
               ctl.id_clr     = (data == pnfc_pkg::CMD_RESET);
               ctl.stage_next = restart;
            end
            pnfc_pkg::STG_AA, pnfc_pkg::STG_ERS_AA: begin
               if (at_b && data == pnfc_pkg::DAT_55) begin
                  ctl.stage_next = (stage == pnfc_pkg::STG_AA) ? pnfc_pkg::STG_CMD
                                                               : pnfc_pkg::STG_ERS_CMD;
               end else begin
                  ctl.stage_next = restart;
               end
            end
            pnfc_pkg::STG_CMD: begin
               if (!at_a) begin
                  ctl.stage_next = restart;
               end else if (data == pnfc_pkg::CMD_PROG) begin
                  ctl.stage_next = pnfc_pkg::STG_PROG;
               end else if (data == pnfc_pkg::CMD_ERASE) begin
                  ctl.stage_next = pnfc_pkg::STG_ERS;
               end else if (data == pnfc_pkg::CMD_ID) begin
                  ctl.id_set     = 1'b1;
                  ctl.stage_next = pnfc_pkg::STG_IDLE;
               end else if (data == pnfc_pkg::CMD_RESET) begin
                  ctl.id_clr     = 1'b1;
                  ctl.stage_next = pnfc_pkg::STG_IDLE;
               end else begin
                  ctl.stage_next = restart;
               end
            end
            pnfc_pkg::STG_PROG: begin
               ctl.prog       = 1'b1;
               ctl.stage_next = pnfc_pkg::STG_IDLE;
            end
            pnfc_pkg::STG_ERS: begin
               ctl.stage_next = (at_a && data == pnfc_pkg::DAT_AA) ? pnfc_pkg::STG_ERS_AA
                                                                   : pnfc_pkg::STG_IDLE;
            end
            pnfc_pkg::STG_ERS_CMD: begin
               if (data == pnfc_pkg::CMD_SECTOR) begin
                  ctl.erase_sect = 1'b1;
                  ctl.stage_next = pnfc_pkg::STG_IDLE;
               end else if (data == pnfc_pkg::CMD_CHIP && at_a) begin
                  ctl.erase_chip = 1'b1;
                  ctl.stage_next = pnfc_pkg::STG_IDLE;
               end else begin
                  ctl.stage_next = restart;
               end
            end
            default: begin
               ctl.stage_next = pnfc_pkg::STG_IDLE;
            end
         endcase
      end
   end

endmodule

[design/pnfc_chk.sv]
// Port-level checks for the flash command model, bound to the top level.
module pnfc_chk (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_action,
   input logic       rsp_valid,
   input logic [7:0] rsp_read_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after an accepted beat");

   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_valid)
      else $error("result beat missing two cycles after accept");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat repeated");

   a_data_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_data != 8'h00 |->
         $past(req_action, 2) == pnfc_pkg::ACT_READ)
      else $error("nonzero read data on a non-read beat");

endmodule

bind parallel_nor_flash_command_model_unit pnfc_chk u_pnfc_chk (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_action    (req_action),
   .rsp_valid     (rsp_valid),
   .rsp_read_data (rsp_read_data)
);

[bench/parallel_nor_flash_command_model_unit_tb.sv]
// Self-checking bench for the NOR flash command unit: queued bus beats, own flash image check.
module parallel_nor_flash_command_model_unit_tb;
   import pnfc_pkg::*;

   localparam int MEM_BITS   = 17;
   localparam int SECT_BYTES = 4096;
   localparam int MEM_BYTES  = 1 << MEM_BITS;

   typedef struct {
      action_type  act;
      logic [16:0] addr;
      logic [7:0]  data;
   } bus_op_type;

   typedef struct {
      logic [7:0] read_data;
      logic       busy_res;
   } flash_reply_type;

   logic        clock;
   logic        reset;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = ACT_READ;
   logic [16:0] req_address = '0;
   logic [7:0]  req_write_data = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_read_data;
   logic        rsp_busy_res;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [19:0] csr_wdata;

   parallel_nor_flash_command_model_unit #(
      .ADDR_BITS(MEM_BITS),
      .SECTOR_BYTES(SECT_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_address(req_address),
      .req_write_data(req_write_data),
      .rsp_valid(rsp_valid),
      .rsp_read_data(rsp_read_data),
      .rsp_busy_res(rsp_busy_res),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // expected chip state
   logic [7:0]        flash_img [0:MEM_BYTES-1];
   stage_type         stage;
   logic              id_on;
   logic [BUSY_W-1:0] busy_cnt;
   logic              tog;
   logic              poll_b;
   logic [7:0]        cfg_ven;
   logic [7:0]        cfg_dev;
   logic [9:0]        cfg_prog;
   logic [19:0]       cfg_ers;

   bus_op_type      bus_ops[$];
   flash_reply_type due_replies[$];
   logic       took = 1'b0;
   int         gap_left = 0;
   int         idle_pct = 0;
   int         fail_count = 0;
   int         op_count = 0;
   int         chip_runs = 0;
   int         hot [4];

   function automatic stage_type relock(input logic [CMD_W-1:0] ca, input logic [7:0] d);
      return (ca == UNLOCK_A && d == DAT_AA) ? STG_AA : STG_IDLE;
   endfunction

   task automatic erase_span(input int base, input int len);
      for (int i = base; i < base + len && i < MEM_BYTES; i++)
         flash_img[i] = ERASED;
      poll_b = 1'b0;
      busy_cnt = (cfg_ers == '0) ? BUSY_W'(1) : cfg_ers;
   endtask

   task automatic chip_step(input action_type act, input logic [16:0] a, input logic [7:0] d,
                            output logic [7:0] rd, output logic bsy);
      logic [CMD_W-1:0] ca;
      rd = 8'h00;
      ca = a[CMD_W-1:0];
      case (act)
         ACT_READ: begin
            if (busy_cnt != 0) begin
               rd = {poll_b, tog, 6'b0};
               tog = ~tog;
            end else if (id_on) begin
               rd = a[0] ? cfg_dev : cfg_ven;
            end else begin
               rd = flash_img[a];
            end
         end
         ACT_WRITE: if (busy_cnt == 0) begin
            case (stage)
               STG_IDLE: begin
                  if (d == CMD_RESET) id_on = 1'b0;
                  stage = relock(ca, d);
               end
               STG_AA, STG_ERS_AA: begin
                  if (ca == UNLOCK_B && d == DAT_55)
                     stage = (stage == STG_AA) ? STG_CMD : STG_ERS_CMD;
                  else
                     stage = relock(ca, d);
               end
               STG_CMD: begin
                  stage = STG_IDLE;
                  if (ca != UNLOCK_A) stage = relock(ca, d);
                  else if (d == CMD_PROG) stage = STG_PROG;
                  else if (d == CMD_ERASE) stage = STG_ERS;
                  else if (d == CMD_ID) id_on = 1'b1;
                  else if (d == CMD_RESET) id_on = 1'b0;
                  else stage = relock(ca, d);
               end
               STG_PROG: begin
                  flash_img[a] = flash_img[a] & d;
                  poll_b = ~d[7];
                  busy_cnt = (cfg_prog == '0) ? BUSY_W'(1) : {10'd0, cfg_prog};
                  stage = STG_IDLE;
               end
               STG_ERS: begin
                  stage = (ca == UNLOCK_A && d == DAT_AA) ? STG_ERS_AA : STG_IDLE;
               end
               STG_ERS_CMD: begin
                  stage = STG_IDLE;
                  if (d == CMD_SECTOR)
                     erase_span(int'(a) - int'(a) % SECT_BYTES, SECT_BYTES);
                  else if (d == CMD_CHIP && ca == UNLOCK_A)
                     erase_span(0, MEM_BYTES);
                  else
                     stage = relock(ca, d);
               end
               default: stage = STG_IDLE;
            endcase
         end
         ACT_TICK: if (busy_cnt != 0) busy_cnt--;
         default: ;
      endcase
      bsy = (busy_cnt != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // sender: one beat per handshake, random idle bursts between beats
   always @(negedge clock) begin : drive
      bus_op_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took) begin
         if (start && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            gap_left = $urandom_range(1, 7);
         if (gap_left != 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (bus_ops.size() != 0) begin
            nxt = bus_ops.pop_front();
            req_action <= nxt.act;
            req_address <= nxt.addr;
            req_write_data <= nxt.data;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watch
      logic [7:0] rd;
      logic       bsy;
      flash_reply_type want;
      took <= !reset && start && !busy;
      if (!reset && start && !busy) begin
         chip_step(action_type'(req_action), req_address, req_write_data, rd, bsy);
         due_replies.push_back('{rd, bsy});
      end
      if (!reset && rsp_valid) begin
         if (due_replies.size() == 0) begin
            fail_count++;
            $display("%0t: reply with none due: read_data %h busy_res %b",
                     $time, rsp_read_data, rsp_busy_res);
         end else begin
            want = due_replies.pop_front();
            if (rsp_read_data !== want.read_data) begin
               fail_count++;
               $display("%0t: read_data expected %h actual %h",
                        $time, want.read_data, rsp_read_data);
            end
            if (rsp_busy_res !== want.busy_res) begin
               fail_count++;
               $display("%0t: busy_res expected %b actual %b",
                        $time, want.busy_res, rsp_busy_res);
            end
         end
      end
   end

   task automatic post(input action_type act, input logic [16:0] a, input logic [7:0] d);
      bus_ops.push_back('{act, a, d});
      op_count++;
   endtask

   function automatic logic [16:0] at_cmd(input logic [CMD_W-1:0] lo);
      return {2'($urandom_range(0, 3)), lo};
   endfunction

   function automatic logic [16:0] pick_addr();
      if ($urandom_range(0, 99) < 70)
         return {5'(hot[$urandom_range(0, 3)]), 7'd0, 5'($urandom_range(0, 31))};
      return 17'($urandom);
   endfunction

   function automatic logic [7:0] pick_data();
      logic [7:0] vals [10] = '{DAT_AA, DAT_55, CMD_PROG, CMD_ERASE, CMD_SECTOR, CMD_CHIP,
                                CMD_ID, CMD_RESET, 8'h00, ERASED};
      if ($urandom_range(0, 1) == 0)
         return 8'($urandom);
      return vals[$urandom_range(0, 9)];
   endfunction

   // command write, sometimes preceded by a read or tick that must not disturb the stage
   task automatic seq_wr(input logic [16:0] a, input logic [7:0] d);
      if ($urandom_range(0, 9) == 0)
         post($urandom_range(0, 1) ? ACT_READ : ACT_TICK, pick_addr(), pick_data());
      post(ACT_WRITE, a, d);
   endtask

   task automatic unlock();
      seq_wr(at_cmd(UNLOCK_A), DAT_AA);
      seq_wr(at_cmd(UNLOCK_B), DAT_55);
   endtask

   task automatic wait_out();
      int n;
      n = $urandom_range(0, 10);
      repeat (n) begin
         if ($urandom_range(0, 9) < 7)
            post(ACT_TICK, 17'($urandom), 8'($urandom));
         else
            post(ACT_READ, pick_addr(), pick_data());
      end
   endtask

   task automatic random_group();
      logic [CMD_W-1:0] ers_lo [5] = '{UNLOCK_A, UNLOCK_B, UNLOCK_A, UNLOCK_A, UNLOCK_B};
      logic [7:0]       ers_d  [5] = '{DAT_AA, DAT_55, CMD_ERASE, DAT_AA, DAT_55};
      logic [16:0]      tgt;
      int               r;
      int               n;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 199) == 0 && chip_runs < 2) begin
         chip_runs++;
         unlock();
         seq_wr(at_cmd(UNLOCK_A), CMD_ERASE);
         unlock();
         seq_wr(at_cmd(UNLOCK_A), CMD_CHIP);
         wait_out();
      end else if (r < 25) begin
         tgt = pick_addr();
         unlock();
         seq_wr(at_cmd(UNLOCK_A), CMD_PROG);
         seq_wr(tgt, pick_data());
         wait_out();
         post(ACT_READ, tgt, pick_data());
      end else if (r < 33) begin
         tgt = pick_addr();
         unlock();
         seq_wr(at_cmd(UNLOCK_A), CMD_ERASE);
         unlock();
         seq_wr(tgt, CMD_SECTOR);
         wait_out();
         post(ACT_READ, tgt, pick_data());
      end else if (r < 43) begin
         unlock();
         seq_wr(at_cmd(UNLOCK_A), CMD_ID);
         n = $urandom_range(1, 4);
         repeat (n) post(ACT_READ, pick_addr(), pick_data());
         n = $urandom_range(0, 19);
         if (n < 9) begin
            post(ACT_WRITE, pick_addr(), CMD_RESET);
         end else if (n < 18) begin
            unlock();
            seq_wr(at_cmd(UNLOCK_A), CMD_RESET);
         end
      end else if (r < 58) begin
         n = $urandom_range(1, 3);
         repeat (n) post(ACT_READ, pick_addr(), pick_data());
      end else if (r < 66) begin
         n = $urandom_range(1, 4);
         repeat (n) post(ACT_TICK, 17'($urandom), 8'($urandom));
      end else if (r < 84) begin
         // erase prefix, cut short or complete, then a stray write
         n = $urandom_range(1, 5);
         for (int i = 0; i < n; i++)
            seq_wr(at_cmd(ers_lo[i]), ers_d[i]);
         seq_wr($urandom_range(0, 1) ? at_cmd(UNLOCK_A) : pick_addr(), pick_data());
      end else begin
         post(action_type'($urandom_range(0, 2)),
              $urandom_range(0, 1) ? 17'($urandom) : pick_addr(), pick_data());
      end
   endtask

   task automatic fill_random(input int n);
      op_count = 0;
      while (op_count < n)
         random_group();
   endtask

   task automatic load_regs(input logic [7:0] v, input logic [7:0] dv,
                            input logic [9:0] p, input logic [19:0] e);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_VENDOR;
      csr_wdata <= {12'($urandom), v};
      cfg_ven = v;
      @(negedge clock);
      csr_index <= CSR_DEVICE;
      csr_wdata <= {12'($urandom), dv};
      cfg_dev = dv;
      @(negedge clock);
      csr_index <= CSR_PROG;
      csr_wdata <= {10'($urandom), p};
      cfg_prog = p;
      @(negedge clock);
      csr_index <= CSR_ERASE;
      csr_wdata <= e;
      cfg_ers = e;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (bus_ops.size() != 0 || start || due_replies.size() != 0 || busy)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      #40000000;
      $display("parallel_nor_flash_command_model_unit_tb: FAIL");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_VENDOR;
      csr_wdata = '0;
      for (int i = 0; i < MEM_BYTES; i++)
         flash_img[i] = ERASED;
      stage = STG_IDLE;
      id_on = 1'b0;
      busy_cnt = '0;
      tog = 1'b0;
      poll_b = 1'b0;
      cfg_ven = VENDOR_RST;
      cfg_dev = DEVICE_RST;
      cfg_prog = PROG_RST;
      cfg_ers = ERASE_RST;
      hot = '{0, 31, $urandom_range(1, 30), $urandom_range(1, 30)};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero tick registers, array ends, program, ID mode, last sector erase
      load_regs(8'h00, 8'hFF, 10'd0, 20'd0);
      idle_pct = 30;
      post(ACT_READ, 17'h00000, 8'h00);
      post(ACT_READ, 17'h1FFFF, 8'hFF);
      post(ACT_WRITE, 17'h05555, DAT_AA);
      post(ACT_WRITE, 17'h02AAA, DAT_55);
      post(ACT_WRITE, 17'h05555, CMD_PROG);
      post(ACT_WRITE, 17'h1FFFF, 8'h00);
      post(ACT_READ, 17'h1FFFF, 8'h00);
      post(ACT_TICK, 17'h00000, 8'h00);
      post(ACT_READ, 17'h1FFFF, 8'h00);
      post(ACT_WRITE, 17'h1D555, DAT_AA);
      post(ACT_WRITE, 17'h0AAAA, DAT_55);
      post(ACT_WRITE, 17'h05555, CMD_ID);
      post(ACT_READ, 17'h00000, 8'h00);
      post(ACT_READ, 17'h1FFFF, 8'h00);
      post(ACT_WRITE, 17'h00000, CMD_RESET);
      post(ACT_READ, 17'h00000, 8'h00);
      post(ACT_WRITE, 17'h05555, DAT_AA);
      post(ACT_WRITE, 17'h02AAA, DAT_55);
      post(ACT_WRITE, 17'h05555, CMD_ERASE);
      post(ACT_WRITE, 17'h05555, DAT_AA);
      post(ACT_WRITE, 17'h02AAA, DAT_55);
      post(ACT_WRITE, 17'h1F123, CMD_SECTOR);
      post(ACT_READ, 17'h1FFFF, 8'h00);
      post(ACT_TICK, 17'h00000, 8'h00);
      post(ACT_READ, 17'h1FFFF, 8'h00);
      drain();

      load_regs(8'($urandom), 8'($urandom), 10'($urandom_range(1, 6)),
                20'($urandom_range(1, 8)));
      idle_pct = 40;
      fill_random(400);
      drain();

      load_regs(8'($urandom), 8'($urandom), 10'd1, 20'd1);
      idle_pct = 0;
      fill_random(400);
      drain();

      load_regs(8'hFF, 8'h00, 10'($urandom_range(0, 3)), 20'($urandom_range(0, 3)));
      idle_pct = 60;
      fill_random(400);
      drain();

      load_regs(8'($urandom), 8'($urandom), 10'($urandom_range(1, 12)),
                20'($urandom_range(1, 12)));
      idle_pct = 25;
      fill_random(200);
      drain();

      // longest busy times: once started, the chip stays busy to the end
      load_regs(8'($urandom), 8'($urandom), 10'd1023, 20'hFFFFF);
      idle_pct = 0;
      fill_random(40);
      drain();

      if (fail_count == 0)
         $display("parallel_nor_flash_command_model_unit_tb: PASS");
      else
         $display("parallel_nor_flash_command_model_unit_tb: FAIL");
      $finish;
   end

endmodule
